// File: design/ssid_pkg.sv
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared types, constants and helpers for the salted serial ID block.
// ----------------------------------------------------------------------------
package ssid_pkg;

    localparam int DEF_MAX_SERIAL_DIGITS = 20;
    localparam int NUM_DIGITS            = 20;
    localparam int SERIAL_W              = 64;
    localparam int CFG_IDX_W             = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SALT0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SALT1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SALT2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SALT3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd4;

    localparam logic [1:0] BLK_IPAD  = 2'd0;
    localparam logic [1:0] BLK_TEXT  = 2'd1;
    localparam logic [1:0] BLK_OPAD  = 2'd2;
    localparam logic [1:0] BLK_INNER = 2'd3;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       take;
        logic       conv_step;
        logic       load_blk;
        logic [1:0] blk_sel;
        logic       round;
        logic [5:0] rnd_idx;
        logic       fin;
        logic       make_result;
    } ssid_cmd_t;

    typedef struct packed {
        logic skip;
    } ssid_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [7:0] b32_char(input logic [4:0] v);
        if (v < 5'd26)
            b32_char = 8'h41 + {3'b000, v};
        else
            b32_char = 8'h32 + {3'b000, v} - 8'd26;
    endfunction

endpackage

// File: design/ssid_ctrl.sv
// ----------------------------------------------------------------------------
// ssid_ctrl
// Sequencer: decimal conversion, four compressions, result hand-off.
// ----------------------------------------------------------------------------
module ssid_ctrl
    import ssid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ssid_stat_t stat,
    output ssid_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] blk_reg, blk_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        cmd        = '0;
        cmd.blk_sel = blk_reg;
        cmd.rnd_idx = cnt_reg;
        ov_next    = ov_reg & ~out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    cnt_next = '0;
                    blk_next = BLK_IPAD;
                    state_next = stat.skip ? S_DONE : S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_blk = 1'b1;
                cnt_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                blk_next = blk_reg + 2'd1;
                state_next = (blk_reg == BLK_INNER) ? S_DONE : S_LOAD;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.make_result = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            blk_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// File: design/ssid_datapath.sv
// ----------------------------------------------------------------------------
// ssid_datapath
// Salt registers, binary-to-BCD shifter, block builder, SHA-256 round unit.
// ----------------------------------------------------------------------------
module ssid_datapath
    import ssid_pkg::*;
#(
    parameter int MAX_SERIAL_DIGITS = DEF_MAX_SERIAL_DIGITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [SERIAL_W-1:0]  serial_number,
    input  ssid_cmd_t            cmd,
    output ssid_stat_t           stat,
    output logic [39:0]          id_first_group,
    output logic [39:0]          id_second_group,
    output logic                 available
);

    logic [255:0] salt_reg;
    logic         present_reg;
    logic [63:0]  bin_reg;
    logic [79:0]  bcd_reg;
    logic [79:0]  bcd_adj;
    logic         skip_reg;
    logic [31:0]  hs_reg [8];
    logic [31:0]  wk_reg [8];
    logic [31:0]  w_reg  [16];
    logic [255:0] inner_reg;
    logic [39:0]  g1_reg, g2_reg;
    logic         av_reg;

    logic [4:0]   nd;
    logic [511:0] blk;
    logic [511:0] text_blk;
    logic [10:0]  text_bits;
    logic [31:0]  t1, t2, s0, s1, w_new;
    logic [31:0]  sum [8];
    logic [55:0]  mac56;
    logic [49:0]  top50;

    assign stat.skip = !present_reg || (serial_number == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_reg    <= '0;
            present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SALT0:   salt_reg[255:192] <= cfg_data;
                REG_SALT1:   salt_reg[191:128] <= cfg_data;
                REG_SALT2:   salt_reg[127:64]  <= cfg_data;
                REG_SALT3:   salt_reg[63:0]    <= cfg_data;
                REG_PRESENT: present_reg       <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        nd = 5'd1;
        for (int i = 0; i < NUM_DIGITS; i++)
            if (bcd_reg[4*i +: 4] != 4'd0)
                nd = 5'(i + 1);
    end

    always_comb
    begin
        logic [4:0] idx;
        idx = '0;
        text_blk = '0;
        text_bits = ({6'd0, nd} + 11'd64) << 3;
        for (int j = 0; j <= NUM_DIGITS; j++)
        begin
            idx = nd - 5'd1 - 5'(j);
            if (5'(j) < nd)
                text_blk[511 - 8*j -: 8] = {4'h3, bcd_reg[4*idx +: 4]};
            else if (5'(j) == nd)
                text_blk[511 - 8*j -: 8] = 8'h80;
        end
        text_blk[10:0] = text_bits;
    end

    always_comb
    begin
        unique case (cmd.blk_sel)
            BLK_IPAD:  blk = {salt_reg ^ {32{8'h36}}, {32{8'h36}}};
            BLK_TEXT:  blk = text_blk;
            BLK_OPAD:  blk = {salt_reg ^ {32{8'h5c}}, {32{8'h5c}}};
            BLK_INNER: blk = {inner_reg, 8'h80, 184'd0, 64'd768};
            default:   blk = '0;
        endcase
    end

    always_comb
    begin
        t1 = wk_reg[7] + (rotr(wk_reg[4], 6) ^ rotr(wk_reg[4], 11) ^ rotr(wk_reg[4], 25))
           + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]))
           + K_TABLE[cmd.rnd_idx] + w_reg[0];
        t2 = (rotr(wk_reg[0], 2) ^ rotr(wk_reg[0], 13) ^ rotr(wk_reg[0], 22))
           + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        for (int i = 0; i < 8; i++)
            sum[i] = hs_reg[i] + wk_reg[i];
    end

    assign mac56 = {hs_reg[0], hs_reg[1][31:8]};
    assign top50 = mac56[55:6];

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            bin_reg  <= serial_number;
            bcd_reg  <= '0;
            skip_reg <= stat.skip;
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[78:0], bin_reg[63]};
            bin_reg <= {bin_reg[62:0], 1'b0};
        end

        if (cmd.load_blk)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= blk[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++)
            begin
                if (!cmd.blk_sel[0])
                begin
                    wk_reg[i] <= IV_TABLE[i];
                    hs_reg[i] <= IV_TABLE[i];
                end
                else
                    wk_reg[i] <= hs_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            wk_reg[7] <= wk_reg[6];
            wk_reg[6] <= wk_reg[5];
            wk_reg[5] <= wk_reg[4];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[3] <= wk_reg[2];
            wk_reg[2] <= wk_reg[1];
            wk_reg[1] <= wk_reg[0];
            wk_reg[0] <= t1 + t2;
        end
        else if (cmd.fin)
        begin
            for (int i = 0; i < 8; i++)
                hs_reg[i] <= sum[i];
            if (cmd.blk_sel == BLK_TEXT)
                inner_reg <= {sum[0], sum[1], sum[2], sum[3],
                              sum[4], sum[5], sum[6], sum[7]};
        end

        if (cmd.make_result)
        begin
            if (skip_reg || (32'(nd) > 32'(MAX_SERIAL_DIGITS)))
            begin
                g1_reg <= '0;
                g2_reg <= '0;
                av_reg <= 1'b0;
            end
            else
            begin
                for (int k = 0; k < 5; k++)
                begin
                    g1_reg[39 - 8*k -: 8] <= b32_char(top50[49 - 5*k -: 5]);
                    g2_reg[39 - 8*k -: 8] <= b32_char(top50[24 - 5*k -: 5]);
                end
                av_reg <= 1'b1;
            end
        end
    end

    assign id_first_group  = g1_reg;
    assign id_second_group = g2_reg;
    assign available       = av_reg;

endmodule

// File: design/salted_serial_id_hmac_top.sv
// From an accepted serial to the result: 64 BCD shift steps, then four SHA-256
// compressions on one shared round unit; with no salt or a zero serial both are skipped.
// A new serial is taken only after the last reaches the result register, which frees input.
// Reset (rst_n, async, active low) clears salt registers, salt_present and control state.
// ----------------------------------------------------------------------------
// salted_serial_id_hmac_top
// HMAC-SHA256 of a decimal serial keyed by a 256-bit salt, base32 ID output.
// ----------------------------------------------------------------------------
module salted_serial_id_hmac_top
    import ssid_pkg::*;
#(
    parameter int MAX_SERIAL_DIGITS = DEF_MAX_SERIAL_DIGITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SERIAL_W-1:0]  serial_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [39:0]          id_first_group,
    output logic [39:0]          id_second_group,
    output logic                 available
);

    ssid_cmd_t  cmd;
    ssid_stat_t stat;

    ssid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ssid_datapath #(
        .MAX_SERIAL_DIGITS (MAX_SERIAL_DIGITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .serial_number   (serial_number),
        .cmd             (cmd),
        .stat            (stat),
        .id_first_group  (id_first_group),
        .id_second_group (id_second_group),
        .available       (available)
    );

endmodule
